// File: rtl/core/timed_pwm_actuator_channels_assert.svh
`ifndef TIMED_PWM_ACTUATOR_CHANNELS_ASSERT_SVH
`define TIMED_PWM_ACTUATOR_CHANNELS_ASSERT_SVH

// Same-cycle implication, checked on clk and masked while rst_n is low.
`define TPAC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpac: same-cycle check failed");

// Next-cycle implication, checked on clk and masked while rst_n is low.
`define TPAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpac: next-cycle check failed");

`endif

// File: rtl/core/tpac_pkg.sv
package tpac_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W     = 2;
    localparam int OUT_W    = 4;
    localparam int BTN_W    = 4;
    localparam int TIME_W   = 32;
    localparam int DUR_W    = 31;
    localparam int PER_W    = 16;
    localparam int DUTY_W   = 7;
    localparam int PROD_W   = PER_W + DUTY_W;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    // floor(x / 25) for x below 2^21 as (x * DIV25_MUL) >> DIV25_SHIFT
    localparam int             DIV25_IN_W  = PROD_W - 2;
    localparam int             DIV25_MUL_W = 22;
    localparam int             DIV25_SHIFT = 26;
    localparam int             DIV25_PR_W  = DIV25_IN_W + DIV25_MUL_W;
    localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = 22'd2684355;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_CYCLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_INTERVAL = 1'd1;

    localparam logic [PER_W-1:0] PWM_CYCLE_RST    = 16'd2000;
    localparam logic [PER_W-1:0] BTN_INTERVAL_RST = 16'd100;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_ALL_OFF  = 3'd1,
        OP_ALL_ON   = 3'd2,
        OP_ON       = 3'd3,
        OP_OFF      = 3'd4,
        OP_TIMED_ON = 3'd5,
        OP_SET_PWM  = 3'd6
    } op_t;

    typedef struct packed {
        logic              fire;
        op_t               op;
        logic              sel;
        logic              btn_apply;
        logic              btn_released;
        logic [TIME_W-1:0] time_now;
        logic [TIME_W-1:0] time_tick;
        logic [DUR_W-1:0]  duration;
        logic [PER_W-1:0]  on_period;
        logic [PER_W-1:0]  off_period;
    } ch_ctrl_t;

    typedef struct packed {
        logic pin;
        logic cmd;
        logic pwm;
    } ch_stat_t;

endpackage

// File: rtl/core/tpac_channel.sv
module tpac_channel
(
    input  logic                clk,
    input  logic                rst_n,
    input  tpac_pkg::ch_ctrl_t  ctrl,
    output tpac_pkg::ch_stat_t  stat
);

    logic [tpac_pkg::TIME_W-1:0] ts_reg, ts_next;
    logic [tpac_pkg::DUR_W-1:0]  dur_reg, dur_next;
    logic                        indef_reg, indef_next;
    logic [tpac_pkg::TIME_W-1:0] phase_reg, phase_next;
    logic [tpac_pkg::PER_W-1:0]  on_reg, on_next;
    logic [tpac_pkg::PER_W-1:0]  off_reg, off_next;
    logic                        pwm_reg, pwm_next;
    logic                        cmd_reg, cmd_next;
    logic                        pin_reg, pin_next;

    logic [tpac_pkg::TIME_W-1:0] run_el;
    logic [tpac_pkg::TIME_W-1:0] phase_el;

    assign run_el   = ctrl.time_tick - ts_reg;
    assign phase_el = ctrl.time_tick - phase_reg;

    always_comb
    begin
        ts_next    = ts_reg;
        dur_next   = dur_reg;
        indef_next = indef_reg;
        phase_next = phase_reg;
        on_next    = on_reg;
        off_next   = off_reg;
        pwm_next   = pwm_reg;
        cmd_next   = cmd_reg;
        pin_next   = pin_reg;
        case (ctrl.op)
            tpac_pkg::OP_TICK:
            begin
                // timed run over: drop the output and stop PWM
                if (!indef_reg && (run_el > {1'b0, dur_reg}))
                begin
                    pwm_next   = 1'b0;
                    pin_next   = 1'b0;
                    cmd_next   = 1'b0;
                    indef_next = 1'b1;
                end
                if (pwm_next)
                begin
                    if (cmd_next)
                    begin
                        if (phase_el > {16'd0, on_reg})
                        begin
                            pin_next   = 1'b0;
                            cmd_next   = 1'b0;
                            phase_next = ctrl.time_tick;
                        end
                    end
                    else if (phase_el > {16'd0, off_reg})
                    begin
                        pin_next   = 1'b1;
                        cmd_next   = 1'b1;
                        phase_next = ctrl.time_tick;
                    end
                end
                if (ctrl.btn_apply)
                begin
                    if (!ctrl.btn_released)
                        pin_next = 1'b1;
                    else if (!cmd_next)
                        pin_next = 1'b0;
                end
            end
            tpac_pkg::OP_ALL_OFF:
            begin
                pin_next   = 1'b0;
                cmd_next   = 1'b0;
                indef_next = 1'b1;
                pwm_next   = 1'b0;
            end
            tpac_pkg::OP_ALL_ON:
            begin
                pin_next   = 1'b1;
                cmd_next   = 1'b1;
                indef_next = 1'b1;
            end
            tpac_pkg::OP_ON:
            begin
                if (ctrl.sel)
                begin
                    pin_next   = 1'b1;
                    cmd_next   = 1'b1;
                    indef_next = 1'b1;
                end
            end
            tpac_pkg::OP_OFF:
            begin
                if (ctrl.sel)
                begin
                    pin_next   = 1'b0;
                    cmd_next   = 1'b0;
                    indef_next = 1'b1;
                end
            end
            tpac_pkg::OP_TIMED_ON:
            begin
                if (ctrl.sel)
                begin
                    pin_next   = 1'b1;
                    cmd_next   = 1'b1;
                    ts_next    = ctrl.time_now;
                    dur_next   = ctrl.duration;
                    indef_next = 1'b0;
                end
            end
            tpac_pkg::OP_SET_PWM:
            begin
                if (ctrl.sel)
                begin
                    on_next    = ctrl.on_period;
                    off_next   = ctrl.off_period;
                    pwm_next   = 1'b1;
                    ts_next    = ctrl.time_now;
                    dur_next   = ctrl.duration;
                    indef_next = 1'b0;
                    pin_next   = 1'b1;
                    cmd_next   = 1'b1;
                    phase_next = ctrl.time_now;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg    <= '0;
            dur_reg   <= '0;
            indef_reg <= 1'b0;
            phase_reg <= '0;
            on_reg    <= '0;
            off_reg   <= '0;
            pwm_reg   <= 1'b0;
            cmd_reg   <= 1'b0;
            pin_reg   <= 1'b0;
        end
        else if (ctrl.fire)
        begin
            ts_reg    <= ts_next;
            dur_reg   <= dur_next;
            indef_reg <= indef_next;
            phase_reg <= phase_next;
            on_reg    <= on_next;
            off_reg   <= off_next;
            pwm_reg   <= pwm_next;
            cmd_reg   <= cmd_next;
            pin_reg   <= pin_next;
        end
    end

    assign stat.pin = pin_next;
    assign stat.cmd = cmd_next;
    assign stat.pwm = pwm_next;

endmodule

// File: rtl/core/timed_pwm_actuator_channels.sv
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+------------------------------------------
// input     | in_valid / in_stall         | op, channel, duration_ms, duty_pct, buttons
// result    | out_valid / out_stall       | pin_levels, commanded, pwm_active
// config    | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One request per cycle while in_stall is low: a request waits in the input register,
// where all channels update in parallel, until the output register can take it; its
// result sits in the output register in the cycle after it leaves the input register.
// The duty times cycle product is formed ahead of the input register; the divide by 100
// is a reciprocal multiply in the processing stage.
// Reset is asynchronous, active low; the config port is always ready.
// in_stall rises only while the input register is full and the output register is stalled.

`include "timed_pwm_actuator_channels_assert.svh"

module timed_pwm_actuator_channels
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         op,
    input  logic [tpac_pkg::CH_W-1:0]          channel,
    input  logic [tpac_pkg::DUR_W-1:0]         duration_ms,
    input  logic [tpac_pkg::DUTY_W-1:0]        duty_pct,
    input  logic [tpac_pkg::BTN_W-1:0]         buttons,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tpac_pkg::OUT_W-1:0]         pin_levels,
    output logic [tpac_pkg::OUT_W-1:0]         commanded,
    output logic [tpac_pkg::OUT_W-1:0]         pwm_active,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tpac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpac_pkg::PER_W-1:0]         cfg_data
);

    logic [tpac_pkg::PER_W-1:0] cycle_reg;
    logic [tpac_pkg::PER_W-1:0] interval_reg;

    logic                              s1_valid_reg, s1_valid_next;
    tpac_pkg::op_t                     s1_op_reg;
    logic [tpac_pkg::CH_W-1:0]         s1_ch_reg;
    logic [tpac_pkg::DUR_W-1:0]        s1_dur_reg;
    logic [tpac_pkg::PROD_W-1:0]       s1_prod_reg;
    logic [tpac_pkg::BTN_W-1:0]        s1_btn_reg;

    logic [tpac_pkg::TIME_W-1:0]       time_reg, time_next;
    logic [tpac_pkg::TIME_W-1:0]       last_btn_reg, last_btn_next;

    logic                              out_valid_reg, out_valid_next;
    logic [tpac_pkg::OUT_W-1:0]        pin_levels_reg;
    logic [tpac_pkg::OUT_W-1:0]        commanded_reg;
    logic [tpac_pkg::OUT_W-1:0]        pwm_active_reg;

    logic                              in_fire;
    logic                              s1_advance;
    logic                              s1_fire;
    logic [tpac_pkg::DUTY_W-1:0]       duty_sat;
    logic [tpac_pkg::PROD_W-1:0]       prod_in;
    logic [tpac_pkg::DIV25_PR_W-1:0]   div_prod;
    logic [tpac_pkg::PER_W-1:0]        on_period;
    logic [tpac_pkg::PER_W-1:0]        off_period;
    logic [tpac_pkg::TIME_W-1:0]       tick_time;
    logic                              btn_due;
    logic                              is_tick;

    tpac_pkg::ch_ctrl_t                ctrl [tpac_pkg::CHANNELS];
    tpac_pkg::ch_stat_t                stat [tpac_pkg::CHANNELS];
    logic [tpac_pkg::CHANNELS-1:0]     btn_rel;
    logic [tpac_pkg::CHANNELS-1:0]     pin_all;
    logic [tpac_pkg::CHANNELS-1:0]     cmd_all;
    logic [tpac_pkg::CHANNELS-1:0]     pwm_all;

    // config port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg    <= tpac_pkg::PWM_CYCLE_RST;
            interval_reg <= tpac_pkg::BTN_INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tpac_pkg::CFG_PWM_CYCLE:    cycle_reg    <= cfg_data;
                tpac_pkg::CFG_BTN_INTERVAL: interval_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // handshake
    assign s1_advance = !out_valid_reg || !out_stall;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_fire    = in_valid && !in_stall;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_fire ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // saturate duty and form duty * cycle ahead of the input register
    assign duty_sat = (duty_pct > tpac_pkg::DUTY_MAX) ? tpac_pkg::DUTY_MAX : duty_pct;
    assign prod_in  = tpac_pkg::PROD_W'(duty_sat) * tpac_pkg::PROD_W'(cycle_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg   <= tpac_pkg::op_t'(op);
            s1_ch_reg   <= channel;
            s1_dur_reg  <= duration_ms;
            s1_prod_reg <= prod_in;
            s1_btn_reg  <= buttons;
        end
    end

    // floor(p / 100) = floor(floor(p / 4) / 25)
    assign div_prod = tpac_pkg::DIV25_PR_W'(s1_prod_reg[tpac_pkg::PROD_W-1:2])
                    * tpac_pkg::DIV25_PR_W'(tpac_pkg::DIV25_MUL);
    assign on_period  = div_prod[tpac_pkg::DIV25_SHIFT +: tpac_pkg::PER_W];
    assign off_period = cycle_reg - on_period;

    assign is_tick   = (s1_op_reg == tpac_pkg::OP_TICK);
    assign tick_time = time_reg + 32'd1;
    assign btn_due   = (tick_time - last_btn_reg) > {16'd0, interval_reg};

    assign time_next     = is_tick ? tick_time : time_reg;
    assign last_btn_next = (is_tick && btn_due) ? tick_time : last_btn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            last_btn_reg <= '0;
        end
        else if (s1_fire)
        begin
            time_reg     <= time_next;
            last_btn_reg <= last_btn_next;
        end
    end

    for (genvar i = 0; i < tpac_pkg::CHANNELS; i++)
    begin : g_ch
        // channels without a button input read as released
        if (i < tpac_pkg::BTN_W)
        begin : g_btn
            assign btn_rel[i] = s1_btn_reg[i];
        end
        else
        begin : g_nobtn
            assign btn_rel[i] = 1'b1;
        end

        always_comb
        begin
            ctrl[i].fire         = s1_fire;
            ctrl[i].op           = s1_op_reg;
            ctrl[i].sel          = (s1_ch_reg == tpac_pkg::CH_W'(i));
            ctrl[i].btn_apply    = btn_due;
            ctrl[i].btn_released = btn_rel[i];
            ctrl[i].time_now     = time_reg;
            ctrl[i].time_tick    = tick_time;
            ctrl[i].duration     = s1_dur_reg;
            ctrl[i].on_period    = on_period;
            ctrl[i].off_period   = off_period;
        end

        tpac_channel u_ch
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl[i]),
            .stat  (stat[i])
        );

        assign pin_all[i] = stat[i].pin;
        assign cmd_all[i] = stat[i].cmd;
        assign pwm_all[i] = stat[i].pwm;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            pin_levels_reg <= pin_all[tpac_pkg::OUT_W-1:0];
            commanded_reg  <= cmd_all[tpac_pkg::OUT_W-1:0];
            pwm_active_reg <= pwm_all[tpac_pkg::OUT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign pin_levels = pin_levels_reg;
    assign commanded  = commanded_reg;
    assign pwm_active = pwm_active_reg;

    `TPAC_ASSERT_IMPL(a_stall_only_when_full, in_stall, s1_valid_reg)
    `TPAC_ASSERT_NEXT(a_fire_gives_result, s1_fire, out_valid_reg)
    `TPAC_ASSERT_NEXT(a_blocked_request_kept, in_stall, s1_valid_reg)
    `TPAC_ASSERT_IMPL(a_commanded_pin_high, out_valid_reg,
                      (commanded_reg & ~pin_levels_reg) == '0)
    `TPAC_ASSERT_NEXT(a_tick_advances_time, s1_fire && is_tick,
                      time_reg == $past(time_reg) + 32'd1)

endmodule
